@@ rtl/sstf_pkg.sv @@
// Shared types, codes and the control store of the shortest-seek-first disk scheduler.
package sstf_pkg;

	localparam int FLD_W = 16;
	localparam int STEP_W = 7;
	localparam int SUM_W = 22;
	localparam int UPC_W = 3;

	typedef struct packed {
		logic [FLD_W-1:0] track;
		logic [FLD_W-1:0] start_head;
		logic             last_request;
	} req_t;

	typedef struct packed {
		logic [STEP_W-1:0] step_number;
		logic [FLD_W-1:0]  served_track;
		logic [FLD_W-1:0]  seek_distance;
		logic [SUM_W-1:0]  total_seek;
		logic              last_of_run;
	} res_t;

	localparam logic [1:0] C_ALWAYS    = 2'd0;
	localparam logic [1:0] C_LAST_ACC  = 2'd1;
	localparam logic [1:0] C_SCAN_DONE = 2'd2;
	localparam logic [1:0] C_MORE      = 2'd3;

	localparam logic [UPC_W-1:0] UA_IDLE  = 3'd0;
	localparam logic [UPC_W-1:0] UA_INIT  = 3'd1;
	localparam logic [UPC_W-1:0] UA_SCAN  = 3'd2;
	localparam logic [UPC_W-1:0] UA_EMIT  = 3'd3;
	localparam logic [UPC_W-1:0] UA_CLEAR = 3'd4;

	typedef struct packed {
		logic             busy;
		logic             scan_init;
		logic             scan;
		logic             emit;
		logic             clear;
		logic [1:0]       cond;
		logic [UPC_W-1:0] target;
		logic             stay;
	} ctrl_t;

	typedef struct packed {
		logic last_acc;
		logic scan_done;
		logic more;
	} stat_t;

	function automatic ctrl_t ucode(input logic [UPC_W-1:0] addr);
		ctrl_t cw;
		cw = '0;
		unique case (addr)
			UA_IDLE: begin
				cw.cond   = C_LAST_ACC;
				cw.target = UA_INIT;
				cw.stay   = 1'b1;
			end
			UA_INIT: begin
				cw.busy      = 1'b1;
				cw.scan_init = 1'b1;
				cw.cond      = C_ALWAYS;
				cw.target    = UA_SCAN;
			end
			UA_SCAN: begin
				cw.busy   = 1'b1;
				cw.scan   = 1'b1;
				cw.cond   = C_SCAN_DONE;
				cw.target = UA_EMIT;
				cw.stay   = 1'b1;
			end
			UA_EMIT: begin
				cw.busy   = 1'b1;
				cw.emit   = 1'b1;
				cw.cond   = C_MORE;
				cw.target = UA_INIT;
			end
			UA_CLEAR: begin
				cw.busy   = 1'b1;
				cw.clear  = 1'b1;
				cw.cond   = C_ALWAYS;
				cw.target = UA_IDLE;
			end
			default: begin
				cw.busy   = 1'b1;
				cw.cond   = C_ALWAYS;
				cw.target = UA_IDLE;
			end
		endcase
		return cw;
	endfunction

endpackage

@@ rtl/sstf_useq.sv @@
// Microprogram sequencer: step counter, control store lookup and conditional jumps.
module sstf_useq (
	input  logic           clk,
	input  logic           arst_n,
	input  sstf_pkg::stat_t stat,
	output sstf_pkg::ctrl_t ctrl
);
	import sstf_pkg::*;

	logic [UPC_W-1:0] upc_q;
	logic [UPC_W-1:0] upc_nxt;
	logic             take;

	assign ctrl = ucode(upc_q);

	always_comb begin
		case (ctrl.cond)
			C_ALWAYS:    take = 1'b1;
			C_LAST_ACC:  take = stat.last_acc;
			C_SCAN_DONE: take = stat.scan_done;
			C_MORE:      take = stat.more;
			default:     take = 1'b1;
		endcase
		if (take) begin
			upc_nxt = ctrl.target;
		end else if (ctrl.stay) begin
			upc_nxt = upc_q;
		end else begin
			upc_nxt = upc_q + UPC_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UA_IDLE;
		end else begin
			upc_q <= upc_nxt;
		end
	end

endmodule

@@ rtl/sstf_dpath.sv @@
// Datapath: request memory, served marks, nearest-track scan and result register.
module sstf_dpath #(
	parameter int MAX_REQUESTS = 32,
	parameter int TRACK_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  sstf_pkg::ctrl_t ctrl,
	input  logic            accept,
	input  sstf_pkg::req_t  request,
	output sstf_pkg::stat_t stat,
	output logic            strobe,
	output sstf_pkg::res_t  result
);
	import sstf_pkg::*;

	localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

	logic [TRACK_BITS-1:0] mem [MAX_REQUESTS];
	logic [MAX_REQUESTS-1:0] served_q;

	logic [CNT_W-1:0]      loaded_q;
	logic [CNT_W-1:0]      nserved_q;
	logic [CNT_W-1:0]      ptr_q;
	logic [TRACK_BITS-1:0] head_q;
	logic [SUM_W-1:0]      sum_q;

	logic                  rd_vld_s1;
	logic [IDX_W-1:0]      rd_idx_s1;
	logic [TRACK_BITS-1:0] rd_data_s1;

	logic                  found_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [TRACK_BITS-1:0] best_dist_q;
	logic [TRACK_BITS-1:0] best_trk_q;

	logic                  strobe_q;
	res_t                  res_q;

	logic                  room;
	logic                  rd_en;
	logic [TRACK_BITS-1:0] trk_gap;
	logic                  better;
	logic [CNT_W-1:0]      nserved_inc;
	logic [SUM_W-1:0]      sum_nxt;

	assign room        = (loaded_q < CNT_W'(MAX_REQUESTS));
	assign rd_en       = ctrl.scan && (ptr_q < loaded_q);
	assign trk_gap     = (rd_data_s1 >= head_q) ? (rd_data_s1 - head_q) : (head_q - rd_data_s1);
	assign better      = ctrl.scan && rd_vld_s1 && !served_q[rd_idx_s1] &&
	                     (!found_q || (trk_gap < best_dist_q));
	assign nserved_inc = nserved_q + CNT_W'(1);
	assign sum_nxt     = sum_q + SUM_W'(best_dist_q);

	assign stat.last_acc  = accept && request.last_request;
	assign stat.scan_done = (ptr_q == loaded_q) && !rd_vld_s1;
	assign stat.more      = (nserved_inc != loaded_q);

	assign strobe = strobe_q;
	assign result = res_q;

	always_ff @(posedge clk) begin
		if (accept && room) begin
			mem[loaded_q[IDX_W-1:0]] <= request.track[TRACK_BITS-1:0];
		end
		if (rd_en) begin
			rd_data_s1 <= mem[ptr_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			served_q  <= '0;
			loaded_q  <= '0;
			nserved_q <= '0;
			ptr_q     <= '0;
			head_q    <= '0;
			sum_q     <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= ctrl.emit;
			if (accept) begin
				if (room) begin
					loaded_q <= loaded_q + CNT_W'(1);
				end
				if (request.last_request) begin
					head_q <= request.start_head[TRACK_BITS-1:0];
				end
			end
			if (ctrl.scan_init) begin
				ptr_q     <= '0;
				rd_vld_s1 <= 1'b0;
				found_q   <= 1'b0;
			end
			if (ctrl.scan) begin
				rd_vld_s1 <= rd_en;
				if (rd_en) begin
					ptr_q <= ptr_q + CNT_W'(1);
				end
				if (better) begin
					found_q <= 1'b1;
				end
			end
			if (ctrl.emit) begin
				served_q[best_idx_q] <= 1'b1;
				nserved_q            <= nserved_inc;
				sum_q                <= sum_nxt;
				head_q               <= best_trk_q;
			end
			if (ctrl.clear) begin
				served_q  <= '0;
				loaded_q  <= '0;
				nserved_q <= '0;
				sum_q     <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_idx_s1 <= ptr_q[IDX_W-1:0];
		end
		if (better) begin
			best_idx_q  <= rd_idx_s1;
			best_dist_q <= trk_gap;
			best_trk_q  <= rd_data_s1;
		end
		if (ctrl.emit) begin
			res_q.step_number   <= STEP_W'(nserved_inc);
			res_q.served_track  <= FLD_W'(best_trk_q);
			res_q.seek_distance <= FLD_W'(best_dist_q);
			res_q.total_seek    <= sum_nxt;
			res_q.last_of_run   <= !stat.more;
		end
	end

endmodule

@@ rtl/sstf_disk_scheduler.sv @@
// Top level of the shortest-seek-time-first disk scheduler.
// Usage:
//   Load one request word per cycle with start while busy is low; only the low
//   TRACK_BITS bits of track are kept and words beyond MAX_REQUESTS are dropped.
//   A word with last_request set also samples start_head and starts the run.
//   The block then serves the batch, nearest track to the head first, ties to the
//   earliest loaded request, and shows one result word per pick on result for a
//   single cycle, marked by strobe; last_of_run flags the final pick.
// Sequence:
//   A word without last_request leaves busy low.
//   Each pick sets up the scan, steps through the request memory's registered
//   read port over all N stored requests, compares the final entry and then
//   emits. After the final pick a clear step empties the batch; busy then drops.
// Reset:
//   arst_n clears the batch, the head position and the sequencer; the request
//   memory keeps no reset value. The receiver cannot stall, so results are
//   never held back.
module sstf_disk_scheduler #(
	parameter int MAX_REQUESTS = 32,
	parameter int TRACK_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  sstf_pkg::req_t request,
	output logic           strobe,
	output sstf_pkg::res_t result
);
	import sstf_pkg::*;

	ctrl_t ctrl;
	stat_t stat;
	logic  accept;

	assign busy   = ctrl.busy;
	assign accept = start && !ctrl.busy;

	sstf_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	sstf_dpath #(
		.MAX_REQUESTS (MAX_REQUESTS),
		.TRACK_BITS   (TRACK_BITS)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.accept  (accept),
		.request (request),
		.stat    (stat),
		.strobe  (strobe),
		.result  (result)
	);

endmodule

@@ rtl/sstf_chk.sv @@
// Port-level checker for the disk scheduler and its bind.
module sstf_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input sstf_pkg::req_t request,
	input logic           strobe,
	input sstf_pkg::res_t result
);
	import sstf_pkg::*;

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("result word shown while idle");

	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_of_run |=> busy)
		else $error("busy dropped before batch end");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last_of_run |=> !strobe)
		else $error("result word after batch end");

	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && request.last_request |=> busy && !strobe)
		else $error("run did not start");

	a_load_only: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !request.last_request |=> !busy && !strobe)
		else $error("load word caused activity");

endmodule

bind sstf_disk_scheduler sstf_chk u_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.request (request),
	.strobe  (strobe),
	.result  (result)
);
